### design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and types of the first-fit block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  // Store depth and handle width
  localparam int MAX_UNITS   = 128;
  localparam int HANDLE_BITS = 16;

  // Cell index and cell count widths
  localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int CNT_W = $clog2(MAX_UNITS + 1);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int SIZE_W   = 8;
  localparam int EH_W     = 16;
  localparam int STATUS_W = 2;
  localparam int OUT_H_W  = 16;
  localparam int UC_W     = 8;

  localparam logic [UC_W-1:0] UNIT_COUNT_RST = UC_W'(128);

  typedef logic [HANDLE_BITS-1:0] handle_t;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEFRAG = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL = 2'd2;

endpackage

`default_nettype wire

### design/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator over a store of owner handles, with erase and compaction.
// ----------------------------------------------------------------------------
// Steps: alloc scans for a free run, then fills it cell by cell; erase scans for
//   the handle's run; defragment makes a read/compact pass, then a clear pass over
//   the freed tail.
// Throughput: one request at a time; the store's single read port, walked one
//   cell per cycle, sets the figure. A finished result waits in an output reg.
// Reset: all cells read as free at once (per-cell valid flags), handles restart
//   at 1, unit count goes to 128. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [ffba_pkg::UC_W-1:0]         cfg_wdata_i,
  // request channel
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [ffba_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [ffba_pkg::SIZE_W-1:0]       alloc_size_i,
  input  wire logic signed [ffba_pkg::EH_W-1:0]  erase_handle_i,
  // result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [ffba_pkg::STATUS_W-1:0]     status_o,
  output      logic [ffba_pkg::OUT_H_W-1:0]      handle_o
);

  localparam int IDX_W = ffba_pkg::IDX_W;
  localparam int CNT_W = ffba_pkg::CNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALLOC  = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_ERASE  = 3'd3;
  localparam logic [2:0] S_DEFRAG = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                       state_q, state_d;
  logic [CNT_W-1:0]                 rd_idx_q, rd_idx_d;
  logic                             pend_q, pend_d;
  logic [IDX_W-1:0]                 pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [CNT_W-1:0]                 wr_idx_q, wr_idx_d;
  logic                             found_q, found_d;
  logic [ffba_pkg::SIZE_W-1:0]      size_q, size_d;
  logic [ffba_pkg::EH_W-1:0]        h_q, h_d;
  ffba_pkg::handle_t                next_handle_q, next_handle_d;
  logic [ffba_pkg::STATUS_W-1:0]    res_status_q, res_status_d;
  logic [ffba_pkg::OUT_H_W-1:0]     res_handle_q, res_handle_d;
  logic                             out_valid_q, out_valid_d;
  logic [ffba_pkg::STATUS_W-1:0]    out_status_q, out_status_d;
  logic [ffba_pkg::OUT_H_W-1:0]     out_handle_q, out_handle_d;
  logic [ffba_pkg::UC_W-1:0]        unit_count_q;
  logic [ffba_pkg::MAX_UNITS-1:0]   vld_q;
  logic                             vld_rd_q;

  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  ffba_pkg::handle_t                ram_wdata;
  logic [IDX_W-1:0]                 ram_raddr;
  ffba_pkg::handle_t                ram_rdata;
  logic                             vld_set, vld_clr;
  logic [IDX_W-1:0]                 vld_idx;

  logic [CNT_W-1:0]                 units;
  ffba_pkg::handle_t                cur_owner;
  logic                             scan_more;
  logic [CNT_W-1:0]                 cnt_n;
  logic [ffba_pkg::EH_W-1:0]        eh_bits;

  assign units = (32'(unit_count_q) > 32'(ffba_pkg::MAX_UNITS))
               ? CNT_W'(ffba_pkg::MAX_UNITS) : CNT_W'(unit_count_q);
  assign cur_owner = vld_rd_q ? ram_rdata : '0;
  assign scan_more = rd_idx_q < units;
  assign ram_raddr = rd_idx_q[IDX_W-1:0];
  assign eh_bits   = $unsigned(erase_handle_i);

  ffba_ram #(
    .WIDTH (ffba_pkg::HANDLE_BITS),
    .DEPTH (ffba_pkg::MAX_UNITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d       = state_q;
    rd_idx_d      = rd_idx_q;
    pend_d        = 1'b0;
    pend_idx_d    = pend_idx_q;
    cnt_d         = cnt_q;
    cnt_n         = cnt_q;
    wr_idx_d      = wr_idx_q;
    found_d       = found_q;
    size_d        = size_q;
    h_d           = h_q;
    next_handle_d = next_handle_q;
    res_status_d  = res_status_q;
    res_handle_d  = res_handle_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_handle_d  = out_handle_q;
    ram_we        = 1'b0;
    ram_waddr     = wr_idx_q[IDX_W-1:0];
    ram_wdata     = next_handle_q;
    vld_set       = 1'b0;
    vld_clr       = 1'b0;
    vld_idx       = wr_idx_q[IDX_W-1:0];

    // drop a result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // advance the read stream in every walk state
    if ((state_q == S_ALLOC || state_q == S_ERASE || state_q == S_DEFRAG) && scan_more) begin
      rd_idx_d   = rd_idx_q + CNT_W'(1);
      pend_d     = 1'b1;
      pend_idx_d = rd_idx_q[IDX_W-1:0];
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rd_idx_d = '0;
          pend_d   = 1'b0;
          cnt_d    = '0;
          wr_idx_d = '0;
          found_d  = 1'b0;
          size_d   = alloc_size_i;
          h_d      = eh_bits;
          res_handle_d = '0;
          case (cmd_i)
            ffba_pkg::CMD_ALLOC: begin
              if (alloc_size_i == '0 || next_handle_q == '1 ||
                  32'(alloc_size_i) > 32'(units)) begin
                res_status_d = ffba_pkg::ST_NULL;
                state_d      = S_DONE;
              end else begin
                state_d = S_ALLOC;
              end
            end
            ffba_pkg::CMD_ERASE: begin
              if (eh_bits == '0 || eh_bits[ffba_pkg::EH_W-1] ||
                  32'(eh_bits) > 32'(next_handle_q)) begin
                res_status_d = ffba_pkg::ST_ILLEGAL;
                state_d      = S_DONE;
              end else begin
                state_d = S_ERASE;
              end
            end
            default: begin
              state_d = S_DEFRAG;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (pend_q) begin
          if (cur_owner == '0) begin
            cnt_n = cnt_q + CNT_W'(1);
          end else begin
            cnt_n    = '0;
            wr_idx_d = CNT_W'(pend_idx_q) + CNT_W'(1);
          end
          cnt_d = cnt_n;
          if (32'(cnt_n) == 32'(size_q)) begin
            pend_d  = 1'b0;
            state_d = S_FILL;
          end
        end else if (!scan_more) begin
          res_status_d = ffba_pkg::ST_NULL;
          state_d      = S_DONE;
        end
      end

      S_FILL: begin
        ram_we   = 1'b1;
        vld_set  = 1'b1;
        wr_idx_d = wr_idx_q + CNT_W'(1);
        cnt_d    = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          res_status_d  = ffba_pkg::ST_OK;
          res_handle_d  = ffba_pkg::OUT_H_W'(next_handle_q);
          next_handle_d = next_handle_q + ffba_pkg::HANDLE_BITS'(1);
          state_d       = S_DONE;
        end
      end

      S_ERASE: begin
        if (pend_q) begin
          if (32'(cur_owner) == 32'(h_q)) begin
            vld_clr = 1'b1;
            vld_idx = pend_idx_q;
            found_d = 1'b1;
          end else if (found_q) begin
            // end of the run
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end else if (!scan_more) begin
          if (found_q) begin
            state_d = S_IDLE;
          end else begin
            res_status_d = ffba_pkg::ST_ILLEGAL;
            state_d      = S_DONE;
          end
        end
      end

      S_DEFRAG: begin
        if (pend_q) begin
          if (cur_owner != '0) begin
            ram_we    = 1'b1;
            ram_wdata = cur_owner;
            vld_set   = 1'b1;
            wr_idx_d  = wr_idx_q + CNT_W'(1);
          end
        end else if (!scan_more) begin
          state_d = S_CLEAR;
        end
      end

      S_CLEAR: begin
        if (wr_idx_q < units) begin
          vld_clr  = 1'b1;
          wr_idx_d = wr_idx_q + CNT_W'(1);
        end else begin
          state_d = S_IDLE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_handle_d = res_handle_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pend_q        <= 1'b0;
      found_q       <= 1'b0;
      next_handle_q <= ffba_pkg::HANDLE_BITS'(1);
      out_valid_q   <= 1'b0;
      unit_count_q  <= ffba_pkg::UNIT_COUNT_RST;
      vld_q         <= '0;
      vld_rd_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      pend_q        <= pend_d;
      found_q       <= found_d;
      next_handle_q <= next_handle_d;
      out_valid_q   <= out_valid_d;
      vld_rd_q      <= vld_q[ram_raddr];
      if (cfg_we_i) begin
        unit_count_q <= cfg_wdata_i;
      end
      if (vld_set) begin
        vld_q[vld_idx] <= 1'b1;
      end else if (vld_clr) begin
        vld_q[vld_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    pend_idx_q   <= pend_idx_d;
    cnt_q        <= cnt_d;
    wr_idx_q     <= wr_idx_d;
    size_q       <= size_d;
    h_q          <= h_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    out_status_q <= out_status_d;
    out_handle_q <= out_handle_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign handle_o    = out_handle_q;

endmodule

`default_nettype wire

### design/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output      logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### design/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              cfg_we_i,
  input wire logic [ffba_pkg::UC_W-1:0]         cfg_wdata_i,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [ffba_pkg::CMD_W-1:0]        cmd_i,
  input wire logic [ffba_pkg::SIZE_W-1:0]       alloc_size_i,
  input wire logic signed [ffba_pkg::EH_W-1:0]  erase_handle_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [ffba_pkg::STATUS_W-1:0]     status_o,
  input wire logic [ffba_pkg::OUT_H_W-1:0]      handle_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(handle_o))
    else $error("result changed while stalled");

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken without going busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ffba_pkg::ST_OK || status_o == ffba_pkg::ST_NULL ||
                     status_o == ffba_pkg::ST_ILLEGAL))
    else $error("bad status code");

  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ffba_pkg::ST_OK |-> handle_o == '0)
    else $error("nonzero handle on failed request");

  a_handle_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ffba_pkg::ST_OK |-> handle_o != '0)
    else $error("zero handle on allocation");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);

`default_nettype wire
